>>> rtl/sc1a_pkg.sv
// Shared package for the scancode set 1 decoder: flag bit positions, key codes,
// character tables and the modifier and lookup functions.
// No dependencies.
package sc1a_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int FL_SHIFT  = 0;
   localparam int FL_CTL    = 1;
   localparam int FL_ALT    = 2;
   localparam int FL_CAPS   = 3;
   localparam int FL_NUM    = 4;
   localparam int FL_SCROLL = 5;
   localparam int FL_E0     = 6;
   localparam int FLAG_W    = 7;

   localparam logic [7:0] SC_PREFIX   = 8'hE0;
   localparam logic [7:0] SC_EXT_BIT  = 8'h80;
   localparam logic [7:0] SC_LCTRL    = 8'h1D;
   localparam logic [7:0] SC_RCTRL    = 8'h9D;
   localparam logic [7:0] SC_LSHIFT   = 8'h2A;
   localparam logic [7:0] SC_RSHIFT   = 8'h36;
   localparam logic [7:0] SC_LALT     = 8'h38;
   localparam logic [7:0] SC_RALT     = 8'hB8;
   localparam logic [7:0] SC_CAPS     = 8'h3A;
   localparam logic [7:0] SC_NUM      = 8'h45;
   localparam logic [7:0] SC_SCROLL   = 8'h46;
   localparam logic [7:0] SC_KP_ENTER = 8'h9C;
   localparam logic [7:0] SC_KP_SLASH = 8'hB5;
   localparam logic [7:0] SC_HOME     = 8'h97;
   localparam logic [7:0] SC_UP       = 8'hC8;
   localparam logic [7:0] SC_PGUP     = 8'hC9;
   localparam logic [7:0] SC_LEFT     = 8'hCB;
   localparam logic [7:0] SC_RIGHT    = 8'hCD;
   localparam logic [7:0] SC_END      = 8'hCF;
   localparam logic [7:0] SC_DOWN     = 8'hD0;
   localparam logic [7:0] SC_PGDN     = 8'hD1;
   localparam logic [7:0] SC_INS      = 8'hD2;
   localparam logic [7:0] SC_DEL      = 8'hD3;

   localparam logic [7:0] KC_HOME  = 8'hE0;
   localparam logic [7:0] KC_END   = 8'hE1;
   localparam logic [7:0] KC_UP    = 8'hE2;
   localparam logic [7:0] KC_DOWN  = 8'hE3;
   localparam logic [7:0] KC_LEFT  = 8'hE4;
   localparam logic [7:0] KC_RIGHT = 8'hE5;
   localparam logic [7:0] KC_PGUP  = 8'hE6;
   localparam logic [7:0] KC_PGDN  = 8'hE7;
   localparam logic [7:0] KC_INS   = 8'hE8;
   localparam logic [7:0] KC_DEL   = 8'hE9;
   localparam logic [7:0] KC_NL    = 8'h0A;
   localparam logic [7:0] KC_SLASH = 8'h2F;
   localparam logic [7:0] KC_CSLASH = 8'hEF;
   localparam logic [7:0] KC_NONE  = 8'h00;
   localparam logic [7:0] CASE_OFS = 8'h20;

   localparam int LOW_LEN = 88;
   localparam int CTL_LEN = 56;

   localparam logic [7:0] TAB_NORMAL [0:LOW_LEN-1] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] TAB_SHIFT [0:LOW_LEN-1] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] TAB_CTL [0:CTL_LEN-1] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09,
      8'h0F, 8'h10, 8'h00, 8'h00, 8'h0D, 8'h00, 8'h01, 8'h13,
      8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h1C, 8'h1A, 8'h18, 8'h03, 8'h16,
      8'h02, 8'h0E, 8'h0D, 8'h00, 8'h00, 8'hEF, 8'h00, 8'h00
   };

   typedef logic [FLAG_W-1:0] flags_type;

   typedef struct packed {
      logic [7:0] code;
      logic       ctl;
      logic       shift;
      logic       caps;
      logic       ctl_alt;
   } key_ev_type;

   function automatic flags_type held_mask(input logic [7:0] code);
      flags_type m;
      m = '0;
      unique case (code)
         SC_LCTRL, SC_RCTRL:   m[FL_CTL] = 1'b1;
         SC_LSHIFT, SC_RSHIFT: m[FL_SHIFT] = 1'b1;
         SC_LALT, SC_RALT:     m[FL_ALT] = 1'b1;
         default:              m = '0;
      endcase
      return m;
   endfunction

   function automatic flags_type lock_mask(input logic [7:0] code);
      flags_type m;
      m = '0;
      unique case (code)
         SC_CAPS:   m[FL_CAPS] = 1'b1;
         SC_NUM:    m[FL_NUM] = 1'b1;
         SC_SCROLL: m[FL_SCROLL] = 1'b1;
         default:   m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [7:0] lookup(input logic ctl, input logic shift,
                                         input logic [7:0] code);
      logic [7:0] c;
      c = KC_NONE;
      if (!code[7]) begin
         if (ctl) begin
            if (code < 8'(CTL_LEN)) c = TAB_CTL[code[5:0]];
         end else if (code < 8'(LOW_LEN)) begin
            c = shift ? TAB_SHIFT[code[6:0]] : TAB_NORMAL[code[6:0]];
         end
      end else begin
         unique case (code)
            SC_HOME:     c = KC_HOME;
            SC_KP_ENTER: c = ctl ? KC_NONE : KC_NL;
            SC_KP_SLASH: c = ctl ? KC_CSLASH : KC_SLASH;
            SC_UP:       c = KC_UP;
            SC_PGUP:     c = KC_PGUP;
            SC_LEFT:     c = KC_LEFT;
            SC_RIGHT:    c = KC_RIGHT;
            SC_END:      c = KC_END;
            SC_DOWN:     c = KC_DOWN;
            SC_PGDN:     c = KC_PGDN;
            SC_INS:      c = KC_INS;
            SC_DEL:      c = KC_DEL;
            default:     c = KC_NONE;
         endcase
      end
      return c;
   endfunction

endpackage

>>> rtl/sc1a_front.sv
// Front end: takes scancode bytes, tracks modifier, lock and prefix flags,
// and hands each make code to the queue. Depends on sc1a_pkg.
module sc1a_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   output logic                ev_valid,
   input  logic                ev_ready,
   output sc1a_pkg::key_ev_type ev
);

   sc1a_pkg::flags_type flags_ff, flags_in;
   sc1a_pkg::flags_type f;
   logic [7:0]          code;
   logic                is_make;
   logic                accept;

   assign in_ready = ev_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      f       = flags_ff;
      code    = in_byte;
      is_make = 1'b0;
      priority if (in_byte == sc1a_pkg::SC_PREFIX) begin
         f[sc1a_pkg::FL_E0] = 1'b1;
      end else if (in_byte[7]) begin
         code = flags_ff[sc1a_pkg::FL_E0] ? in_byte : {1'b0, in_byte[6:0]};
         f    = f & ~sc1a_pkg::held_mask(code);
         f[sc1a_pkg::FL_E0] = 1'b0;
      end else begin
         if (flags_ff[sc1a_pkg::FL_E0]) begin
            code = in_byte | sc1a_pkg::SC_EXT_BIT;
            f[sc1a_pkg::FL_E0] = 1'b0;
         end
         f       = f | sc1a_pkg::held_mask(code);
         f       = f ^ sc1a_pkg::lock_mask(code);
         is_make = 1'b1;
      end
   end

   assign flags_in   = accept ? f : flags_ff;
   assign ev_valid   = in_valid && is_make;
   assign ev.code    = code;
   assign ev.ctl     = f[sc1a_pkg::FL_CTL];
   assign ev.shift   = f[sc1a_pkg::FL_SHIFT];
   assign ev.caps    = f[sc1a_pkg::FL_CAPS];
   assign ev.ctl_alt = f[sc1a_pkg::FL_CTL] && f[sc1a_pkg::FL_ALT];

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

endmodule

>>> rtl/sc1a_queue.sv
// Small FIFO of key events between front and back end.
// Depends on sc1a_pkg.
module sc1a_queue #(
   parameter int Depth = sc1a_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 not_full,
   input  sc1a_pkg::key_ev_type push_data,
   input  logic                 pop,
   output logic                 not_empty,
   output sc1a_pkg::key_ev_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   sc1a_pkg::key_ev_type mem [0:Depth-1];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign not_full  = count_ff != CntW'(Depth);
   assign not_empty = count_ff != '0;
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head      = mem[rd_ptr_ff];

   function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/sc1a_back.sv
// Back end: table lookup, caps-lock case swap, reboot detect and the
// output register. Depends on sc1a_pkg.
module sc1a_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ev_valid,
   output logic                 ev_pop,
   input  sc1a_pkg::key_ev_type ev,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_char,
   output logic                 out_reboot
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       reboot_ff;
   logic [7:0] raw, c;
   logic       can_load, load;

   always_comb begin
      raw = sc1a_pkg::lookup(ev.ctl, ev.shift, ev.code);
      c   = raw;
      if (ev.caps) begin
         if (raw >= 8'h61 && raw <= 8'h7A) c = raw - sc1a_pkg::CASE_OFS;
         else if (raw >= 8'h41 && raw <= 8'h5A) c = raw + sc1a_pkg::CASE_OFS;
      end
   end

   assign can_load = !valid_ff || out_ready;
   assign ev_pop   = ev_valid && (c == sc1a_pkg::KC_NONE || can_load);
   assign load     = ev_valid && can_load && c != sc1a_pkg::KC_NONE;

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (out_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff   <= c;
         reboot_ff <= ev.ctl_alt && c == sc1a_pkg::KC_DEL;
      end
   end

   assign out_valid  = valid_ff;
   assign out_char   = char_ff;
   assign out_reboot = reboot_ff;

endmodule

>>> rtl/scancode_set1_to_ascii_unit.sv
// PS/2 scancode set 1 decoder, one byte per request, up to one character out.
// Accepts one scancode per cycle when the event queue has room; a character
// reaches rsp through the queue and then the output register.
// The front end updates shift/ctrl/alt, lock and E0-prefix flags in the cycle
// a byte is accepted; the back end looks up the character, applies caps lock
// and flags Ctrl+Alt+Del on rsp_tuser. Codes without a character produce no
// response. Sustained rate is one request per cycle while the queue has room.
// Depends on sc1a_pkg, sc1a_front, sc1a_queue and sc1a_back.
module scancode_set1_to_ascii_unit #(
   parameter int QueueDepth = sc1a_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] key_char
   output logic       rsp_tuser    // [0] reboot_request
);

   logic                 ev_valid, ev_ready;
   sc1a_pkg::key_ev_type ev, head;
   logic                 q_valid, q_pop;

   sc1a_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .ev_valid (ev_valid),
      .ev_ready (ev_ready),
      .ev       (ev)
   );

   sc1a_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_valid),
      .not_full  (ev_ready),
      .push_data (ev),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (head)
   );

   sc1a_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ev_valid   (q_valid),
      .ev_pop     (q_pop),
      .ev         (head),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_char   (rsp_tdata),
      .out_reboot (rsp_tuser)
   );

endmodule
